FILE: rtl/core/u2u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_pkg: shared types and constants of the UTF-16 to UTF-8 transcoder
// Holds the surrogate range limits, the queue entry layout and the queue
// status group used between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  localparam int unsigned UnitW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodePointW = 21;
  localparam int unsigned HighBitsW  = 10;
  localparam int unsigned MaxBytes   = 4;
  localparam int unsigned ByteIdxW   = 2;

  // Default depth of the queue between front end and back end.
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [UnitW-1:0] HiFirst = 16'hD800;
  localparam logic [UnitW-1:0] HiLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LoFirst = 16'hDC00;
  localparam logic [UnitW-1:0] LoLast  = 16'hDFFF;

  localparam logic [CodePointW-1:0] SuppBase   = 21'h10000;
  localparam logic [CodePointW-1:0] SubstChar  = 21'h00003F;
  localparam logic [CodePointW-1:0] OneByteLim = 21'h000080;
  localparam logic [CodePointW-1:0] TwoByteLim = 21'h000800;

  typedef enum logic [1:0] {
    ClassPlain,
    ClassHigh,
    ClassLow
  } unit_class_e;

  // One encoded code point waiting to be sent out byte by byte.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;     // bytes[0] goes out first
    logic [ByteIdxW-1:0]            last_idx;  // index of the final byte
    logic                           str_end;   // unit closed the string
  } enc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/core/u2u8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_front: code unit classification and UTF-8 encoding
// Classifies each accepted unit, keeps a pending high surrogate, forms the
// code point and encodes it into one to four bytes for the queue.
// ----------------------------------------------------------------------------
module u2u8_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [u2u8_pkg::UnitW-1:0]   code_unit_i,
  input  logic                         string_end_i,
  output logic                         enq_o,
  output u2u8_pkg::enc_entry_t         entry_o
);
  import u2u8_pkg::*;

  logic [HighBitsW-1:0]  held_bits_q, held_bits_d;
  logic                  held_q, held_d;
  unit_class_e           unit_class;
  logic [CodePointW-1:0] code_point;
  logic                  hold_unit;

  always_comb begin
    if (code_unit_i >= HiFirst && code_unit_i <= HiLast) begin
      unit_class = ClassHigh;
    end else if (code_unit_i >= LoFirst && code_unit_i <= LoLast) begin
      unit_class = ClassLow;
    end else begin
      unit_class = ClassPlain;
    end
  end

  assign hold_unit = (unit_class == ClassHigh) && !string_end_i;

  always_comb begin
    case (unit_class)
      ClassHigh: begin
        code_point = SubstChar;
      end
      ClassLow: begin
        if (held_q) begin
          code_point = SuppBase + {1'b0, held_bits_q, code_unit_i[HighBitsW-1:0]};
        end else begin
          code_point = SubstChar;
        end
      end
      default: begin
        code_point = {5'd0, code_unit_i};
      end
    endcase
  end

  always_comb begin
    entry_o.str_end = string_end_i;
    entry_o.bytes   = '0;
    if (code_point < OneByteLim) begin
      entry_o.last_idx = 2'd0;
      entry_o.bytes[0] = code_point[7:0];
    end else if (code_point < TwoByteLim) begin
      entry_o.last_idx = 2'd1;
      entry_o.bytes[0] = {3'b110, code_point[10:6]};
      entry_o.bytes[1] = {2'b10, code_point[5:0]};
    end else if (code_point < SuppBase) begin
      entry_o.last_idx = 2'd2;
      entry_o.bytes[0] = {4'b1110, code_point[15:12]};
      entry_o.bytes[1] = {2'b10, code_point[11:6]};
      entry_o.bytes[2] = {2'b10, code_point[5:0]};
    end else begin
      entry_o.last_idx = 2'd3;
      entry_o.bytes[0] = {5'b11110, code_point[20:18]};
      entry_o.bytes[1] = {2'b10, code_point[17:12]};
      entry_o.bytes[2] = {2'b10, code_point[11:6]};
      entry_o.bytes[3] = {2'b10, code_point[5:0]};
    end
  end

  assign enq_o = accept_i && !hold_unit;

  always_comb begin
    held_d      = held_q;
    held_bits_d = held_bits_q;
    if (accept_i) begin
      held_d      = hold_unit;
      held_bits_d = hold_unit ? code_unit_i[HighBitsW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_bits_q <= '0;
    end else begin
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
    end
  end

  // Nothing may carry over into the next string.
  a_end_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && string_end_i |=> !held_q)
    else $error("high surrogate still held after end of string");

  // A held high surrogate never produces a queue entry by itself.
  a_hold_no_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && hold_unit |-> !enq_o ##1 held_q)
    else $error("held high surrogate produced output");

endmodule

FILE: rtl/core/u2u8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_queue: short entry queue between front end and back end
// A small register queue of encoded code points that decouples the two sides.
// ----------------------------------------------------------------------------
module u2u8_queue #(
  parameter int unsigned Depth = u2u8_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enq_i,
  input  u2u8_pkg::enc_entry_t enq_entry_i,
  input  logic                 deq_i,
  output u2u8_pkg::enc_entry_t head_o,
  output u2u8_pkg::q_status_t  status_o
);
  import u2u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  enc_entry_t            slots_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_enq, do_deq;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_enq = enq_i && !status_o.full;
  assign do_deq = deq_i && !status_o.empty;
  assign head_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_enq) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_enq && !do_deq) begin
      count_d = count_q + 1'b1;
    end else if (do_deq && !do_enq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      slots_q[wr_ptr_q] <= enq_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");

endmodule

FILE: rtl/core/u2u8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_back: byte serializer
// Walks the bytes of the head queue entry into a one-entry output register,
// one byte per cycle unless pop_i stalls, and releases the entry after its final byte.
// ----------------------------------------------------------------------------
module u2u8_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  u2u8_pkg::enc_entry_t          head_i,
  input  u2u8_pkg::q_status_t           q_status_i,
  output logic                          deq_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [u2u8_pkg::ByteW-1:0]    out_byte_o,
  output logic                          run_last_o,
  output logic                          string_last_o
);
  import u2u8_pkg::*;

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_byte_q;
  logic                run_last_q, string_last_q;
  logic                load, final_byte;

  assign load       = !q_status_i.empty && (!out_valid_q || pop_i);
  assign final_byte = (idx_q == head_i.last_idx);
  assign deq_o      = load && final_byte;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = final_byte ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q    <= head_i.bytes[idx_q];
      run_last_q    <= final_byte;
      string_last_q <= final_byte && head_i.str_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = string_last_q;

  // A partly sent entry stays at the head of the queue.
  a_partial_keeps_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> !q_status_i.empty)
    else $error("byte index running without a queue entry");

  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> idx_q <= head_i.last_idx)
    else $error("byte index past the end of the entry");

  // The string end flag only ever rides on the final byte of a unit.
  a_string_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && string_last_q |-> run_last_q)
    else $error("string end flag on an inner byte");

endmodule

FILE: rtl/core/utf16_to_utf8_transcoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core: UTF-16 code units in, UTF-8 bytes out
// Top level tying the encoding front end, the entry queue and the byte
// serializer together behind two queue-style ports.
// ----------------------------------------------------------------------------
// The block takes one UTF-16 code unit per request on the push/full side and
// delivers the UTF-8 bytes of every finished code point, oldest first, on the
// empty/pop side; run_last_o marks the final byte of each unit's output and
// string_last_o marks that byte when the unit carried string_end_i. A unit is
// classified and encoded in the cycle it is accepted, so a new unit can be
// taken every cycle while the queue has room. The output side moves one byte
// per cycle while pop stays high, through a single output register. A plain
// unit yields one to three UTF-8 bytes and a surrogate pair yields four, its
// high half emitting nothing. A high surrogate is held until the next unit;
// if that is a low surrogate the two form a supplementary code point,
// otherwise the held half is dropped. A lone low surrogate, or a high
// surrogate on the last unit of a string, produces a '?' byte. Nothing is
// held across a string end.
module utf16_to_utf8_transcoder_core #(
  parameter int unsigned QueueDepth = u2u8_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [u2u8_pkg::UnitW-1:0]    code_unit_i,
  input  logic                          string_end_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [u2u8_pkg::ByteW-1:0]    out_byte_o,
  output logic                          run_last_o,
  output logic                          string_last_o
);
  import u2u8_pkg::*;

  logic       accept;
  logic       enq, deq;
  enc_entry_t enq_entry, head;
  q_status_t  q_status;

  // The front end takes a unit whenever the queue has a free slot.
  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  u2u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .enq_o        (enq),
    .entry_o      (enq_entry)
  );

  // Encoded code points wait here so either side can stall alone.
  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_i       (enq),
    .enq_entry_i (enq_entry),
    .deq_i       (deq),
    .head_o      (head),
    .status_o    (q_status)
  );

  // The back end streams the head entry out one byte per cycle while pop stays high.
  u2u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .deq_o         (deq),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

endmodule

FILE: dv/utf16_to_utf8_transcoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core_tb: self-checking bench of the transcoder core
// A driver pushes directed and random UTF-16 code units from a request queue,
// a bench-side encoder predicts the UTF-8 byte stream, and a monitor pops the
// bytes and checks each one with its run and string end flags.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core_tb;

  // Clock half period, largest idle draw, settle time after the last byte,
  // watchdog limit and size of the random part.
  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned MaxWait     = 8;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomUnits = 350;

  // UTF-16 surrogate ranges and the substitution byte, kept apart from the
  // design package so that the expected stream is worked out independently.
  localparam logic [15:0] HighFirst   = 16'hD800;
  localparam logic [15:0] HighLast    = 16'hDBFF;
  localparam logic [15:0] LowFirst    = 16'hDC00;
  localparam logic [15:0] LowLast     = 16'hDFFF;
  localparam logic [20:0] SuppOffset  = 21'h10000;
  localparam logic [20:0] Replacement = 21'h00003F;

  // Kinds of random code units; pairs are the only way into four-byte output.
  typedef enum int {
    KindAscii,
    KindTwoByte,
    KindThreeByte,
    KindPair,
    KindLoneLow,
    KindLoneHigh,
    KindAny
  } unit_kind_e;

  // One pending request: the unit, its string end flag, the number of idle
  // cycles before it is offered, and whether the sender first waits until
  // every predicted byte has been popped.
  typedef struct {
    logic [u2u8_pkg::UnitW-1:0] unit;
    logic                       last;
    int unsigned                gap;
    bit                         drain;
  } unit_req_t;

  // One predicted output byte with its flags.
  typedef struct {
    logic [u2u8_pkg::ByteW-1:0] data;
    logic                       run_last;
    logic                       string_last;
  } utf8_byte_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         push          = 1'b0;
  logic                         full;
  logic [u2u8_pkg::UnitW-1:0]   code_unit_i   = '0;
  logic                         string_end_i  = 1'b0;
  logic                         empty;
  logic                         pop           = 1'b0;
  logic [u2u8_pkg::ByteW-1:0]   out_byte_o;
  logic                         run_last_o;
  logic                         string_last_o;

  unit_req_t   pending_units[$];
  utf8_byte_t  utf8_expected[$];

  // Surrogate state of the bench-side encoder.
  logic [9:0]  held_hi_bits = '0;
  bit          held_hi      = 1'b0;

  // Byte counts on both sides. The checked count moves by nonblocking
  // assignment so the driver sees a settled value at every edge.
  int unsigned n_bytes_predicted = 0;
  int unsigned n_bytes_checked   = 0;
  int unsigned n_errors          = 0;
  int unsigned cycle_count       = 0;

  // Idle state of both sides. A burst flag switches idling off for a stretch.
  int unsigned tx_wait  = 0;
  bit          tx_busy  = 1'b0;
  bit          tx_burst = 1'b0;
  int unsigned rx_wait  = 0;
  bit          rx_burst = 1'b0;
  utf8_byte_t  rx_head;

  utf16_to_utf8_transcoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_last_o(string_last_o)
  );

  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  // Works out the UTF-8 bytes that one accepted code unit causes and appends
  // them to the expected stream. A high surrogate that is not the last unit
  // of its string is only held; a later one of that kind replaces it, and any
  // other unit that is not a low surrogate drops it.
  task automatic encode_unit(input logic [15:0] unit, input logic last);
    logic [20:0]      cp;
    logic [3:0][7:0]  seq;
    int               n;
    if (unit >= HighFirst && unit <= HighLast && !last) begin
      held_hi_bits = unit[9:0];
      held_hi      = 1'b1;
    end else begin
      if (unit >= HighFirst && unit <= HighLast) begin
        // A high surrogate closing a string has no partner: substitute.
        cp = Replacement;
      end else if (unit >= LowFirst && unit <= LowLast) begin
        cp = held_hi ? SuppOffset + {1'b0, held_hi_bits, unit[9:0]} : Replacement;
      end else begin
        cp = {5'd0, unit};
      end
      held_hi      = 1'b0;
      held_hi_bits = '0;
      seq          = '0;
      if (cp < 21'h80) begin
        seq[0] = cp[7:0];
        n      = 1;
      end else if (cp < 21'h800) begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
        n      = 2;
      end else if (cp < 21'h10000) begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
        n      = 3;
      end else begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        n      = 4;
      end
      for (int k = 0; k < n; k++) begin
        utf8_expected.push_back('{seq[k], (k == n - 1), (k == n - 1) && last});
      end
      n_bytes_predicted += n;
    end
  endtask

  // Queues one request; its idle gap follows the current sender burst mode.
  task automatic add_unit(input logic [15:0] unit, input logic last, input bit drain = 1'b0);
    unit_req_t req;
    req.unit  = unit;
    req.last  = last;
    req.gap   = tx_burst ? 0 : $urandom_range(0, MaxWait);
    req.drain = drain;
    pending_units.push_back(req);
  endtask

  // Sender. At each edge it first notes whether the request on the ports was
  // taken, and if so hands it to the encoder. With the ports free it counts
  // down the next request's idle gap and then presents it. push gets exactly
  // one nonblocking assignment per edge, so back-to-back requests keep it high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push         <= 1'b0;
      code_unit_i  <= '0;
      string_end_i <= 1'b0;
      tx_wait      = 0;
    end else begin
      tx_busy = push;
      if (push && !full) begin
        encode_unit(code_unit_i, string_end_i);
        tx_busy = 1'b0;
      end
      if (!tx_busy && pending_units.size() != 0) begin
        // A draining request holds the sender until the output side has
        // caught up with everything predicted so far.
        if (!(pending_units[0].drain && n_bytes_checked != n_bytes_predicted)) begin
          if (tx_wait < pending_units[0].gap) begin
            tx_wait++;
          end else begin
            code_unit_i  <= pending_units[0].unit;
            string_end_i <= pending_units[0].last;
            void'(pending_units.pop_front());
            tx_wait = 0;
            tx_busy = 1'b1;
          end
        end
      end
      push <= tx_busy;
    end
  end

  // Receiver. A byte popped at this edge is compared with the oldest
  // prediction; after each one the receiver draws how long it stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop     <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (utf8_expected.size() == 0) begin
          $error("out_byte: no byte expected, got %02h", out_byte_o);
          n_errors++;
        end else begin
          rx_head = utf8_expected.pop_front();
          if (out_byte_o !== rx_head.data) begin
            $error("out_byte: expected %02h, got %02h", rx_head.data, out_byte_o);
            n_errors++;
          end
          if (run_last_o !== rx_head.run_last) begin
            $error("run_last: expected %0b, got %0b", rx_head.run_last, run_last_o);
            n_errors++;
          end
          if (string_last_o !== rx_head.string_last) begin
            $error("string_last: expected %0b, got %0b", rx_head.string_last,
                   string_last_o);
            n_errors++;
          end
        end
        n_bytes_checked <= n_bytes_checked + 1;
        if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, MaxWait);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      pop <= (rx_wait == 0);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("utf16_to_utf8_transcoder_core verification failed");
      $finish;
    end
  end

  initial begin
    unit_kind_e   kind;
    int unsigned  pick;
    int unsigned  n_random;
    logic         last;
    bit           drain;
    logic [15:0]  unit;

    // Directed part: the edges of each UTF-8 length class, both ends of the
    // surrogate ranges, and every surrogate corner case.
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hD7FF, 1'b0);
    // Smallest and largest supplementary code points.
    add_unit(HighFirst, 1'b0);
    add_unit(LowFirst, 1'b0);
    add_unit(HighLast, 1'b0);
    add_unit(LowLast, 1'b0);
    // A lone low surrogate, the first one after a full drain of the output.
    add_unit(LowFirst, 1'b0, 1'b1);
    add_unit(LowLast, 1'b1);
    // A held high surrogate dropped by a plain unit.
    add_unit(16'hD83D, 1'b0);
    add_unit(16'h0041, 1'b0);
    // A second high surrogate replaces the held one before the low half.
    add_unit(HighFirst, 1'b0);
    add_unit(HighLast, 1'b0);
    add_unit(LowFirst, 1'b0);
    // A high surrogate closing the string, alone and after a held one.
    add_unit(16'hD801, 1'b1);
    add_unit(HighFirst, 1'b0);
    add_unit(16'hDAAA, 1'b1);
    // Top of the basic plane, then a pair closing a string.
    add_unit(16'hE000, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    add_unit(16'hD834, 1'b0);
    add_unit(16'hDD1E, 1'b1);

    // Random part: mostly well-formed text with pairs, plus lone surrogates
    // and raw 16-bit noise. Idling on the sender comes and goes in stretches.
    n_random = 0;
    while (n_random < RandomUnits) begin
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      last  = ($urandom_range(0, 7) == 0);
      drain = ($urandom_range(0, 79) == 0);
      pick  = $urandom_range(0, 15);
      kind  = pick < 3  ? KindAscii :
              pick < 5  ? KindTwoByte :
              pick < 8  ? KindThreeByte :
              pick < 12 ? KindPair :
              pick < 13 ? KindLoneLow :
              pick < 14 ? KindLoneHigh : KindAny;
      case (kind)
        KindAscii: begin
          add_unit(16'($urandom_range(16'h0000, 16'h007F)), last, drain);
        end
        KindTwoByte: begin
          add_unit(16'($urandom_range(16'h0080, 16'h07FF)), last, drain);
        end
        KindThreeByte: begin
          unit = 16'($urandom_range(16'h0800, 16'hFFFF));
          // Move surrogate values out into the plain range.
          if (unit >= HighFirst && unit <= LowLast) unit ^= 16'h4000;
          add_unit(unit, last, drain);
        end
        KindPair: begin
          add_unit(HighFirst | 16'($urandom_range(0, 1023)), 1'b0, drain);
          add_unit(LowFirst | 16'($urandom_range(0, 1023)), last);
          n_random++;
        end
        KindLoneLow: begin
          add_unit(LowFirst | 16'($urandom_range(0, 1023)), last, drain);
        end
        KindLoneHigh: begin
          add_unit(HighFirst | 16'($urandom_range(0, 1023)), last, drain);
        end
        default: begin
          add_unit(16'($urandom_range(0, 16'hFFFF)), last, drain);
        end
      endcase
      n_random++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every predicted byte is popped,
    // then give the block time to show any stray extra byte.
    do begin
      @(negedge clk_i);
    end while (pending_units.size() != 0 || push || utf8_expected.size() != 0);
    repeat (TailCycles) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("utf16_to_utf8_transcoder_core verification clean");
    end else begin
      $display("utf16_to_utf8_transcoder_core verification failed");
    end
    $finish;
  end

endmodule
